// ===== design/sup_pkg.sv =====
// Shared types, constants and helpers for the pulse/wave sound unit.
// No dependencies; imported by sup_front, sup_back and the top level.
`timescale 1ns / 1ps

package sup_pkg;

    localparam int unsigned NUM_CHAN_REGS = 20;
    localparam int unsigned WAVE_DEPTH    = 16;
    localparam int unsigned WAVE_IDX_W    = $clog2(WAVE_DEPTH);
    localparam int unsigned WAVE_BASE     = 10;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [15:0] ADDR_CHAN_FIRST = 16'hFF10;
    localparam logic [15:0] ADDR_CHAN_LAST  = 16'hFF23;
    localparam logic [15:0] ADDR_MASTER     = 16'hFF24;
    localparam logic [15:0] ADDR_PAN        = 16'hFF25;
    localparam logic [15:0] ADDR_POWER      = 16'hFF26;
    localparam logic [15:0] ADDR_WAVE_FIRST = 16'hFF30;
    localparam logic [15:0] ADDR_WAVE_LAST  = 16'hFF3F;

    localparam logic [7:0]  UNMAPPED_BYTE = 8'hFF;
    localparam logic [12:0] FRAME_PERIOD  = 13'd2048;
    localparam logic [23:0] CLOCK_HZ      = 24'd1048576;
    localparam logic [15:0] SAMPLE_HZ     = 16'd48000;

    localparam logic [3:0][7:0] DUTY_PATTERNS = {8'h7E, 8'h87, 8'h81, 8'h01};

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  cyc;
    } t_cmd;

    typedef enum logic [1:0] {
        S_EXEC,
        S_READ,
        S_SETTLE,
        S_EMIT
    } t_state;

    // timer reload: (2048 - freq) * 4 for pulse, * 2 for wave
    function automatic logic [13:0] f_reload(input logic [2:0] hi, input logic [7:0] lo,
                                             input logic is_wave);
        logic [11:0] span;
        span = 12'd2048 - {1'b0, hi, lo};
        f_reload = is_wave ? {1'b0, span, 1'b0} : {span, 2'b00};
    endfunction

endpackage

// ===== design/sup_if.sv =====
// Valid/ready channel interfaces for the sound unit's item input and result output.
// Depends on nothing.
`timescale 1ns / 1ps

interface sup_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  cycles;

    modport source(output valid, func, address, write_data, cycles, input ready);
    modport sink(input valid, func, address, write_data, cycles, output ready);
endinterface

interface sup_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] read_data;
    logic [3:0] pulse1_level;
    logic [3:0] pulse2_level;
    logic [3:0] wave_level;
    logic [2:0] active_mask;
    logic       any_dac_on;
    logic       last_of_run;

    modport source(output valid, kind, read_data, pulse1_level, pulse2_level, wave_level,
                   active_mask, any_dac_on, last_of_run, input ready);
    modport sink(input valid, kind, read_data, pulse1_level, pulse2_level, wave_level,
                 active_mask, any_dac_on, last_of_run, output ready);
endinterface

// ===== design/sup_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sup_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sup_front.sv =====
// Front end: accepts items, drops those of unknown function and queues the rest as commands.
// Depends on sup_pkg and sup_if.
`timescale 1ns / 1ps

module sup_front import sup_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sup_in_if.sink i_in,
    output t_cmd   o_cmd,
    output logic   o_cmd_valid,
    input  logic   i_cmd_ready
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;
    logic       keep;
    t_cmd       cmd_in;

    always_comb begin
        keep          = 1'b1;
        cmd_in.addr   = i_in.address;
        cmd_in.data   = i_in.write_data;
        cmd_in.cyc    = i_in.cycles;
        cmd_in.op     = OP_TICK;
        unique case (i_in.func)
            FUNC_TICK:  cmd_in.op = OP_TICK;
            FUNC_WRITE: cmd_in.op = OP_WRITE;
            FUNC_READ:  cmd_in.op = OP_READ;
            default:    keep = 1'b0;
        endcase
    end

    assign i_in.ready  = (r_count != 2'd2);
    assign push        = i_in.valid && i_in.ready && keep;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !pop) |=> r_count == 2'd2)
        else $error("full queue lost an entry");

endmodule

// ===== design/sup_back.sv =====
// Back end: register map, channel timers, frame sequencer and sample emission.
// Depends on sup_pkg, sup_if and sup_ram (two copies of the wave table).
`timescale 1ns / 1ps

module sup_back import sup_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    sup_out_if.source o_out
);

    t_state      r_state, n_state;
    logic [7:0]  r_chan [NUM_CHAN_REGS];
    logic [7:0]  n_chan [NUM_CHAN_REGS];
    logic [7:0]  r_master, n_master;
    logic [7:0]  r_pan, n_pan;
    logic [7:0]  r_power, n_power;
    logic [13:0] r_timer [3];
    logic [13:0] n_timer [3];
    logic [2:0]  r_duty_pos [2];
    logic [2:0]  n_duty_pos [2];
    logic [4:0]  r_wave_pos, n_wave_pos;
    logic [8:0]  r_len [3];
    logic [8:0]  n_len [3];
    logic [3:0]  r_vol [2];
    logic [3:0]  n_vol [2];
    logic [1:0]  r_wcode, n_wcode;
    logic [2:0]  r_env_per [2];
    logic [2:0]  n_env_per [2];
    logic [2:0]  r_env_tmr [2];
    logic [2:0]  n_env_tmr [2];
    logic        r_env_up [2];
    logic        n_env_up [2];
    logic [11:0] r_frame_acc, n_frame_acc;
    logic [2:0]  r_frame_step, n_frame_step;
    logic [23:0] r_sample_acc, n_sample_acc;
    logic [15:0] r_rd_addr, n_rd_addr;
    logic [WAVE_DEPTH-1:0] r_wv_valid, n_wv_valid;

    logic       r_o_valid;
    logic       r_o_kind, n_o_kind;
    logic [7:0] r_o_read, n_o_read;
    logic [3:0] r_o_p1, n_o_p1;
    logic [3:0] r_o_p2, n_o_p2;
    logic [3:0] r_o_wave, n_o_wave;
    logic [2:0] r_o_mask, n_o_mask;
    logic       r_o_dac, n_o_dac;
    logic       r_o_last, n_o_last;

    logic                  out_free;
    logic                  out_load;
    logic                  take;
    logic                  ram_we;
    logic [WAVE_IDX_W-1:0] bus_raddr;
    logic [7:0]            bus_rdata;
    logic [7:0]            wave_rdata;
    logic [9:0]            dec;
    logic [12:0]           frame_sum;
    logic [2:0]            step_new;
    logic [23:0]           sample_inc;
    logic [23:0]           sample_left;
    logic [4:0]            idx;
    logic [4:0]            rd_idx;
    logic [7:0]            v;
    logic [7:0]            entry;
    logic [3:0]            nib;
    logic                  duty_bit;
    logic [7:0]            rd_byte;
    logic [2:0]            t_tmp;

    assign out_free    = !r_o_valid || o_out.ready;
    assign o_cmd_ready = (r_state == S_EXEC);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign v           = i_cmd.data;
    assign idx         = 5'(i_cmd.addr[7:0] - ADDR_CHAN_FIRST[7:0]);
    assign rd_idx      = 5'(r_rd_addr[7:0] - ADDR_CHAN_FIRST[7:0]);
    assign dec         = {i_cmd.cyc, 2'b00};
    assign frame_sum   = {1'b0, r_frame_acc} + {5'b0, i_cmd.cyc};
    assign step_new    = r_frame_step + 3'd1;
    assign sample_inc  = 24'(i_cmd.cyc) * 24'(SAMPLE_HZ);
    assign sample_left = r_sample_acc - CLOCK_HZ;
    assign bus_raddr   = (r_state == S_EXEC) ? i_cmd.addr[WAVE_IDX_W-1:0]
                                             : r_rd_addr[WAVE_IDX_W-1:0];
    assign ram_we      = take && i_cmd.op == OP_WRITE
                         && i_cmd.addr >= ADDR_WAVE_FIRST && i_cmd.addr <= ADDR_WAVE_LAST;

    sup_ram #(.WIDTH(8), .DEPTH(WAVE_DEPTH)) u_ram_bus (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_cmd.addr[WAVE_IDX_W-1:0]),
        .i_wdata(v),
        .i_raddr(bus_raddr),
        .o_rdata(bus_rdata)
    );

    sup_ram #(.WIDTH(8), .DEPTH(WAVE_DEPTH)) u_ram_wave (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_cmd.addr[WAVE_IDX_W-1:0]),
        .i_wdata(v),
        .i_raddr(r_wave_pos[4:1]),
        .o_rdata(wave_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EXEC: begin
                if (take && i_cmd.op == OP_READ) n_state = S_READ;
                else if (take && i_cmd.op == OP_TICK && r_power[7]) n_state = S_SETTLE;
            end
            S_READ: begin
                if (out_free) n_state = S_EXEC;
            end
            S_SETTLE: n_state = S_EMIT;
            S_EMIT: begin
                if (r_sample_acc < CLOCK_HZ) n_state = S_EXEC;
                else if (out_free && sample_left < CLOCK_HZ) n_state = S_EXEC;
            end
            default: n_state = S_EXEC;
        endcase
    end

    // read byte of the register map
    always_comb begin
        rd_byte = UNMAPPED_BYTE;
        if (r_rd_addr >= ADDR_CHAN_FIRST && r_rd_addr <= ADDR_CHAN_LAST)
            rd_byte = r_chan[rd_idx];
        else if (r_rd_addr == ADDR_MASTER)
            rd_byte = r_master;
        else if (r_rd_addr == ADDR_PAN)
            rd_byte = r_pan;
        else if (r_rd_addr == ADDR_POWER)
            rd_byte = r_power;
        else if (r_rd_addr >= ADDR_WAVE_FIRST && r_rd_addr <= ADDR_WAVE_LAST)
            rd_byte = r_wv_valid[r_rd_addr[WAVE_IDX_W-1:0]] ? bus_rdata : 8'h00;
    end

    // datapath and outputs
    always_comb begin
        n_chan       = r_chan;
        n_master     = r_master;
        n_pan        = r_pan;
        n_power      = r_power;
        n_timer      = r_timer;
        n_duty_pos   = r_duty_pos;
        n_wave_pos   = r_wave_pos;
        n_len        = r_len;
        n_vol        = r_vol;
        n_wcode      = r_wcode;
        n_env_per    = r_env_per;
        n_env_tmr    = r_env_tmr;
        n_env_up     = r_env_up;
        n_frame_acc  = r_frame_acc;
        n_frame_step = r_frame_step;
        n_sample_acc = r_sample_acc;
        n_rd_addr    = r_rd_addr;
        n_wv_valid   = r_wv_valid;
        out_load     = 1'b0;
        n_o_kind     = 1'b0;
        n_o_read     = 8'h00;
        n_o_p1       = 4'h0;
        n_o_p2       = 4'h0;
        n_o_wave     = 4'h0;
        n_o_mask     = 3'b000;
        n_o_dac      = 1'b0;
        n_o_last     = 1'b0;
        entry        = 8'h00;
        nib          = 4'h0;
        duty_bit     = 1'b0;
        t_tmp        = 3'd0;
        unique case (r_state)
            S_EXEC: begin
                if (take) begin
                    unique case (i_cmd.op)
                        OP_WRITE: begin
                            if (i_cmd.addr >= ADDR_CHAN_FIRST && i_cmd.addr <= ADDR_CHAN_LAST) begin
                                for (int ch = 0; ch < 2; ch++) begin
                                    if (idx == 5'(5 * ch + 1))
                                        n_len[ch] = 9'd64 - {3'b0, v[5:0]};
                                    if (idx == 5'(5 * ch + 2)) begin
                                        n_vol[ch]     = v[7:4];
                                        n_env_per[ch] = v[2:0];
                                        n_env_tmr[ch] = v[2:0];
                                        n_env_up[ch]  = v[3];
                                    end
                                    if (idx == 5'(5 * ch + 4) && v[7]) begin
                                        n_power[ch] = 1'b1;
                                        if (r_len[ch] == 9'd0) n_len[ch] = 9'd64;
                                        n_timer[ch]   = f_reload(v[2:0], r_chan[5 * ch + 3], 1'b0);
                                        n_vol[ch]     = r_chan[5 * ch + 2][7:4];
                                        n_env_tmr[ch] = r_env_per[ch];
                                        if (r_chan[5 * ch + 2][7:3] == 5'd0) n_power[ch] = 1'b0;
                                    end
                                end
                                if (idx == 5'(WAVE_BASE) && !v[7]) n_power[2] = 1'b0;
                                if (idx == 5'(WAVE_BASE + 1)) n_len[2] = 9'd256 - {1'b0, v};
                                if (idx == 5'(WAVE_BASE + 2)) n_wcode = v[6:5];
                                if (idx == 5'(WAVE_BASE + 4) && v[7]) begin
                                    n_power[2] = 1'b1;
                                    if (r_len[2] == 9'd0) n_len[2] = 9'd256;
                                    n_timer[2] = f_reload(v[2:0], r_chan[WAVE_BASE + 3], 1'b1);
                                end
                                n_chan[idx] = v;
                            end else if (i_cmd.addr == ADDR_MASTER) begin
                                n_master = v;
                            end else if (i_cmd.addr == ADDR_PAN) begin
                                n_pan = v;
                            end else if (i_cmd.addr == ADDR_POWER) begin
                                n_power = v;
                            end else if (ram_we) begin
                                n_wv_valid[i_cmd.addr[WAVE_IDX_W-1:0]] = 1'b1;
                            end
                        end
                        OP_READ: n_rd_addr = i_cmd.addr;
                        OP_TICK: begin
                            if (r_power[7]) begin
                                for (int ch = 0; ch < 3; ch++) begin
                                    if (r_timer[ch] > {4'b0, dec}) begin
                                        n_timer[ch] = r_timer[ch] - {4'b0, dec};
                                    end else begin
                                        n_timer[ch] = f_reload(r_chan[5 * ch + 4][2:0],
                                                               r_chan[5 * ch + 3], ch == 2);
                                        if (ch < 2) n_duty_pos[ch % 2] = r_duty_pos[ch % 2] + 3'd1;
                                        else n_wave_pos = r_wave_pos + 5'd1;
                                    end
                                end
                                n_frame_acc = frame_sum[11:0];
                                if (frame_sum >= FRAME_PERIOD) begin
                                    n_frame_acc  = 12'(frame_sum - FRAME_PERIOD);
                                    n_frame_step = step_new;
                                    if (!step_new[0]) begin
                                        for (int ch = 0; ch < 3; ch++) begin
                                            if (r_chan[5 * ch + 4][6]) begin
                                                if (r_len[ch] != 9'd0) n_len[ch] = r_len[ch] - 9'd1;
                                                if (n_len[ch] == 9'd0) n_power[ch] = 1'b0;
                                            end
                                        end
                                    end
                                    if (step_new == 3'd7) begin
                                        for (int ch = 0; ch < 2; ch++) begin
                                            if (n_power[ch] && r_env_per[ch] != 3'd0) begin
                                                t_tmp = r_env_tmr[ch] - 3'd1;
                                                n_env_tmr[ch] = t_tmp;
                                                if (t_tmp == 3'd0) begin
                                                    n_env_tmr[ch] = r_env_per[ch];
                                                    if (r_env_up[ch] && r_vol[ch] < 4'd15)
                                                        n_vol[ch] = r_vol[ch] + 4'd1;
                                                    if (!r_env_up[ch] && r_vol[ch] > 4'd0)
                                                        n_vol[ch] = r_vol[ch] - 4'd1;
                                                end
                                            end
                                        end
                                    end
                                end
                                n_sample_acc = r_sample_acc + sample_inc;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_o_read = rd_byte;
                    n_o_last = 1'b1;
                end
            end
            S_SETTLE: ;
            S_EMIT: begin
                if (r_sample_acc >= CLOCK_HZ && out_free) begin
                    out_load     = 1'b1;
                    n_o_kind     = 1'b1;
                    n_sample_acc = sample_left;
                    n_o_last     = (sample_left < CLOCK_HZ);
                    duty_bit     = DUTY_PATTERNS[r_chan[1][7:6]][r_duty_pos[0]];
                    n_o_p1       = (r_power[0] && duty_bit) ? r_vol[0] : 4'h0;
                    duty_bit     = DUTY_PATTERNS[r_chan[6][7:6]][r_duty_pos[1]];
                    n_o_p2       = (r_power[1] && duty_bit) ? r_vol[1] : 4'h0;
                    entry        = r_wv_valid[r_wave_pos[4:1]] ? wave_rdata : 8'h00;
                    nib          = r_wave_pos[0] ? entry[3:0] : entry[7:4];
                    if (r_power[2]) begin
                        unique case (r_wcode)
                            2'd0:    n_o_wave = 4'h0;
                            2'd1:    n_o_wave = nib;
                            2'd2:    n_o_wave = nib >> 1;
                            default: n_o_wave = nib >> 2;
                        endcase
                    end
                    n_o_mask = r_power[2:0];
                    n_o_dac  = (r_power[2:0] != 3'b000);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_kind <= n_o_kind;
            r_o_read <= n_o_read;
            r_o_p1   <= n_o_p1;
            r_o_p2   <= n_o_p2;
            r_o_wave <= n_o_wave;
            r_o_mask <= n_o_mask;
            r_o_dac  <= n_o_dac;
            r_o_last <= n_o_last;
        end
        r_rd_addr <= n_rd_addr;
        if (!i_rst_n) begin
            r_state      <= S_EXEC;
            r_o_valid    <= 1'b0;
            r_master     <= 8'h00;
            r_pan        <= 8'h00;
            r_power      <= 8'h00;
            r_wave_pos   <= 5'd0;
            r_wcode      <= 2'd0;
            r_frame_acc  <= 12'd0;
            r_frame_step <= 3'd0;
            r_sample_acc <= 24'd0;
            r_wv_valid   <= '0;
            for (int i = 0; i < NUM_CHAN_REGS; i++) r_chan[i] <= 8'h00;
            for (int i = 0; i < 3; i++) begin
                r_timer[i] <= 14'd0;
                r_len[i]   <= 9'd0;
            end
            for (int i = 0; i < 2; i++) begin
                r_duty_pos[i] <= 3'd0;
                r_vol[i]      <= 4'd0;
                r_env_per[i]  <= 3'd0;
                r_env_tmr[i]  <= 3'd0;
                r_env_up[i]   <= 1'b0;
            end
        end else begin
            r_state      <= n_state;
            r_master     <= n_master;
            r_pan        <= n_pan;
            r_power      <= n_power;
            r_wave_pos   <= n_wave_pos;
            r_wcode      <= n_wcode;
            r_frame_acc  <= n_frame_acc;
            r_frame_step <= n_frame_step;
            r_sample_acc <= n_sample_acc;
            r_wv_valid   <= n_wv_valid;
            r_chan       <= n_chan;
            r_timer      <= n_timer;
            r_len        <= n_len;
            r_duty_pos   <= n_duty_pos;
            r_vol        <= n_vol;
            r_env_per    <= n_env_per;
            r_env_tmr    <= n_env_tmr;
            r_env_up     <= n_env_up;
            if (out_load) r_o_valid <= 1'b1;
            else if (o_out.ready) r_o_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.kind         = r_o_kind;
    assign o_out.read_data    = r_o_read;
    assign o_out.pulse1_level = r_o_p1;
    assign o_out.pulse2_level = r_o_p2;
    assign o_out.wave_level   = r_o_wave;
    assign o_out.active_mask  = r_o_mask;
    assign o_out.any_dac_on   = r_o_dac;
    assign o_out.last_of_run  = r_o_last;

    a_idle_acc_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> r_sample_acc < CLOCK_HZ)
        else $error("sample accumulator left a due sample behind");

    a_frame_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_acc < FRAME_PERIOD[11:0] || r_frame_acc == 12'd0)
        else $error("frame accumulator overran");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_out.ready) |=> !$past(out_load))
        else $error("output register overwritten while stalled");

    a_sample_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_o_kind && n_o_last) |=> r_state == S_EXEC)
        else $error("last sample did not end the run");

endmodule

// ===== design/sound_unit_pulse_wave_channels_core.sv =====
// Pulse/wave sound unit top level: front queue feeding the execution back end.
// Register write: done in the back end. Read: address registered, result loaded in S_READ.
// Tick: S_SETTLE, then S_EMIT gives one sample per cycle unless stalled (up to 12 per tick).
// Throughput is set by the back end, which executes one queued command at a time.
// Synchronous active-low reset clears all channel state, the wave table valid bits and queue.
`timescale 1ns / 1ps

module sound_unit_pulse_wave_channels_core import sup_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sup_in_if.sink    i_in,
    sup_out_if.source o_out
);

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;

    sup_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_cmd      (cmd),
        .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready)
    );

    sup_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready),
        .o_out      (o_out)
    );

endmodule

// ===== test/sound_unit_pulse_wave_channels_core_test.sv =====
// Self-checking testbench for sound_unit_pulse_wave_channels_core: register reads, writes,
// triggers and ticks are predicted in step with the block and each result is compared.
// Depends on sup_pkg, sup_if and the block's RTL.
`timescale 1ns / 1ps

module sound_unit_pulse_wave_channels_core_test;
    import sup_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [15:0] A_NR10 = 16'hFF10, A_NR11 = 16'hFF11, A_NR12 = 16'hFF12;
    localparam logic [15:0] A_NR13 = 16'hFF13, A_NR14 = 16'hFF14;
    localparam logic [15:0] A_NR21 = 16'hFF16, A_NR22 = 16'hFF17;
    localparam logic [15:0] A_NR24 = 16'hFF19;
    localparam logic [15:0] A_NR30 = 16'hFF1A, A_NR32 = 16'hFF1C;
    localparam logic [15:0] A_NR34 = 16'hFF1E;
    localparam logic [15:0] A_UNMAPPED = 16'hFF27;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int unsigned SAMPLE_STEP = 48000;
    localparam int unsigned MCLK = 1048576;

    typedef struct packed {
        logic       kind;
        logic [7:0] read_data;
        logic [3:0] p1;
        logic [3:0] p2;
        logic [3:0] wave;
        logic [2:0] mask;
        logic       dac;
        logic       last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sup_in_if  in_if();
    sup_out_if out_if();

    sound_unit_pulse_wave_channels_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted unit state
    logic [7:0]  chan_reg [20];
    logic [7:0]  master_vol, pan, power;
    logic [7:0]  wave_ram [16];
    int unsigned freq_tmr [3];
    logic [2:0]  duty_pos [2];
    logic [4:0]  wave_pos;
    int unsigned len_cnt [3];
    logic [3:0]  vol [2];
    logic [1:0]  wave_vol;
    logic [2:0]  env_per [2], env_tmr [2];
    logic        env_up [2];
    int unsigned frame_acc;
    logic [2:0]  frame_step;
    int unsigned sample_acc;

    logic [7:0] duty_shape [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

    t_result pending_results[$];
    int errors = 0;
    int samples_seen = 0;
    int reads_seen = 0;
    int items_sent = 0;
    bit idling_on = 1'b1;
    int hold_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    function automatic int unsigned reload(logic [7:0] hi, logic [7:0] lo, int unsigned mult);
        return (2048 - {hi[2:0], lo}) * mult;
    endfunction

    task automatic sound_reset_state();
        foreach (chan_reg[i]) chan_reg[i] = '0;
        foreach (wave_ram[i]) wave_ram[i] = '0;
        master_vol = '0; pan = '0; power = '0;
        for (int c = 0; c < 3; c++) begin
            freq_tmr[c] = 0;
            len_cnt[c] = 0;
        end
        for (int c = 0; c < 2; c++) begin
            duty_pos[c] = '0; vol[c] = '0; env_per[c] = '0; env_tmr[c] = '0; env_up[c] = 1'b0;
        end
        wave_pos = '0; wave_vol = '0; frame_acc = 0; frame_step = '0; sample_acc = 0;
    endtask

    task automatic write_pulse(int c, int off, logic [7:0] v);
        int base;
        base = c * 5;
        if (off == 1) len_cnt[c] = 64 - v[5:0];
        if (off == 2) begin
            vol[c] = v[7:4];
            env_per[c] = v[2:0];
            env_tmr[c] = v[2:0];
            env_up[c] = v[3];
        end
        if (off == 4 && v[7]) begin
            power[c] = 1'b1;
            if (len_cnt[c] == 0) len_cnt[c] = 64;
            freq_tmr[c] = reload(v, chan_reg[base + 3], 4);
            vol[c] = chan_reg[base + 2][7:4];
            env_tmr[c] = env_per[c];
            if (chan_reg[base + 2][7:3] == 0) power[c] = 1'b0;
        end
        chan_reg[base + off] = v;
    endtask

    task automatic write_wave(int off, logic [7:0] v);
        if (off == 0 && !v[7]) power[2] = 1'b0;
        if (off == 1) len_cnt[2] = 256 - v;
        if (off == 2) wave_vol = v[6:5];
        if (off == 4 && v[7]) begin
            power[2] = 1'b1;
            if (len_cnt[2] == 0) len_cnt[2] = 256;
            freq_tmr[2] = reload(v, chan_reg[13], 2);
        end
        chan_reg[10 + off] = v;
    endtask

    task automatic advance_timer(int c, int unsigned dec);
        if (freq_tmr[c] > dec) begin
            freq_tmr[c] -= dec;
        end else if (c < 2) begin
            freq_tmr[c] = reload(chan_reg[c * 5 + 4], chan_reg[c * 5 + 3], 4);
            duty_pos[c] = duty_pos[c] + 3'd1;
        end else begin
            freq_tmr[c] = reload(chan_reg[14], chan_reg[13], 2);
            wave_pos = wave_pos + 5'd1;
        end
    endtask

    task automatic frame_tick();
        frame_step = frame_step + 3'd1;
        if (!frame_step[0]) begin
            for (int c = 0; c < 3; c++) begin
                if (chan_reg[c * 5 + 4][6]) begin
                    if (len_cnt[c] != 0) len_cnt[c]--;
                    if (len_cnt[c] == 0) power[c] = 1'b0;
                end
            end
        end
        if (frame_step == 3'd7) begin
            for (int c = 0; c < 2; c++) begin
                if (power[c] && env_per[c] != 0) begin
                    env_tmr[c] = env_tmr[c] - 3'd1;
                    if (env_tmr[c] == 0) begin
                        env_tmr[c] = env_per[c];
                        if (env_up[c] && vol[c] < 15) vol[c]++;
                        if (!env_up[c] && vol[c] > 0) vol[c]--;
                    end
                end
            end
        end
    endtask

    function automatic logic [3:0] pulse_out(int c);
        logic [7:0] shape;
        shape = duty_shape[chan_reg[c * 5 + 1][7:6]];
        if (!power[c] || !shape[duty_pos[c]]) return 4'd0;
        return vol[c];
    endfunction

    function automatic logic [3:0] wave_out();
        logic [7:0] entry;
        logic [3:0] s;
        if (!power[2]) return 4'd0;
        entry = wave_ram[wave_pos[4:1]];
        s = wave_pos[0] ? entry[3:0] : entry[7:4];
        case (wave_vol)
            2'd0: s = 4'd0;
            2'd1: ;
            2'd2: s = s >> 1;
            default: s = s >> 2;
        endcase
        return s;
    endfunction

    task automatic predict_sound(logic [1:0] func, logic [15:0] addr, logic [7:0] v,
                                 logic [7:0] cyc);
        t_result r;
        int n;
        n = 0;
        if (func == FUNC_WRITE) begin
            if (addr >= 16'hFF10 && addr <= 16'hFF14) write_pulse(0, addr - 16'hFF10, v);
            else if (addr >= 16'hFF15 && addr <= 16'hFF19) write_pulse(1, addr - 16'hFF15, v);
            else if (addr >= A_NR30 && addr <= A_NR34) write_wave(addr - A_NR30, v);
            else if (addr >= 16'hFF1F && addr <= ADDR_CHAN_LAST) chan_reg[addr - A_NR10] = v;
            else if (addr == ADDR_MASTER) master_vol = v;
            else if (addr == ADDR_PAN) pan = v;
            else if (addr == ADDR_POWER) power = v;
            else if (addr >= ADDR_WAVE_FIRST && addr <= ADDR_WAVE_LAST)
                wave_ram[addr - ADDR_WAVE_FIRST] = v;
        end else if (func == FUNC_READ) begin
            r = '0;
            r.read_data = 8'hFF;
            if (addr >= ADDR_CHAN_FIRST && addr <= ADDR_CHAN_LAST)
                r.read_data = chan_reg[addr - ADDR_CHAN_FIRST];
            else if (addr == ADDR_MASTER) r.read_data = master_vol;
            else if (addr == ADDR_PAN) r.read_data = pan;
            else if (addr == ADDR_POWER) r.read_data = power;
            else if (addr >= ADDR_WAVE_FIRST && addr <= ADDR_WAVE_LAST)
                r.read_data = wave_ram[addr - ADDR_WAVE_FIRST];
            r.last = 1'b1;
            pending_results.push_back(r);
        end else if (func == FUNC_TICK && power[7]) begin
            advance_timer(1, cyc * 4);
            advance_timer(0, cyc * 4);
            advance_timer(2, cyc * 4);
            frame_acc += cyc;
            if (frame_acc >= 2048) begin
                frame_acc -= 2048;
                frame_tick();
            end
            sample_acc += cyc * SAMPLE_STEP;
            while (sample_acc >= MCLK && n < 12) begin
                sample_acc -= MCLK;
                r = '0;
                r.kind = 1'b1;
                r.p1 = pulse_out(0);
                r.p2 = pulse_out(1);
                r.wave = wave_out();
                r.mask = power[2:0];
                r.dac = |power[2:0];
                pending_results.push_back(r);
                n++;
            end
            if (n > 0) pending_results[$].last = 1'b1;
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic [1:0] func, logic [15:0] addr, logic [7:0] v,
                             logic [7:0] cyc);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.func = func;
        in_if.address = addr;
        in_if.write_data = v;
        in_if.cycles = cyc;
        do @(posedge i_clk); while (!in_if.ready);
        predict_sound(func, addr, v, cyc);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, kind", out_if.kind, 0);
            end else begin
                w = pending_results.pop_front();
                if (out_if.kind != w.kind) report_mismatch("kind", out_if.kind, w.kind);
                if (out_if.read_data != w.read_data)
                    report_mismatch("read_data", out_if.read_data, w.read_data);
                if (out_if.pulse1_level != w.p1)
                    report_mismatch("pulse1_level", out_if.pulse1_level, w.p1);
                if (out_if.pulse2_level != w.p2)
                    report_mismatch("pulse2_level", out_if.pulse2_level, w.p2);
                if (out_if.wave_level != w.wave)
                    report_mismatch("wave_level", out_if.wave_level, w.wave);
                if (out_if.active_mask != w.mask)
                    report_mismatch("active_mask", out_if.active_mask, w.mask);
                if (out_if.any_dac_on != w.dac)
                    report_mismatch("any_dac_on", out_if.any_dac_on, w.dac);
                if (out_if.last_of_run != w.last)
                    report_mismatch("last_of_run", out_if.last_of_run, w.last);
                if (w.kind) samples_seen++;
                else reads_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (in_if.valid || pending_results.size() != 0) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results pending", pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: long holds on request, random stall bursts otherwise while idling is on
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_item(FUNC_READ, A_NR10, 8'h00, 8'h00);
        send_item(FUNC_READ, A_UNMAPPED, 8'h00, 8'h00);
        send_item(FUNC_READ, 16'h0000, 8'h00, 8'h00);
        send_item(FUNC_TICK, 16'h0000, 8'h00, 8'hFF);          // all channels off
        send_item(FUNC_WRITE, ADDR_POWER, 8'h80, 8'h00);
        send_item(FUNC_WRITE, A_NR12, 8'h00, 8'h00);
        send_item(FUNC_WRITE, A_NR14, 8'h87, 8'h00);            // trigger with dac off
        send_item(FUNC_WRITE, A_NR11, 8'hFF, 8'h00);
        send_item(FUNC_WRITE, A_NR12, 8'hF1, 8'h00);
        send_item(FUNC_WRITE, A_NR13, 8'hFF, 8'h00);
        send_item(FUNC_WRITE, A_NR14, 8'hC7, 8'h00);            // max frequency
        send_item(FUNC_WRITE, A_NR21, 8'h80, 8'h00);
        send_item(FUNC_WRITE, A_NR22, 8'h09, 8'h00);
        send_item(FUNC_WRITE, A_NR24, 8'h80, 8'h00);
        send_item(FUNC_WRITE, ADDR_WAVE_FIRST, 8'hF0, 8'h00);
        send_item(FUNC_WRITE, ADDR_WAVE_LAST, 8'h5A, 8'h00);
        send_item(FUNC_WRITE, A_NR30, 8'h80, 8'h00);
        send_item(FUNC_WRITE, A_NR32, 8'h20, 8'h00);
        send_item(FUNC_WRITE, A_NR34, 8'h87, 8'h00);
        send_item(FUNC_WRITE, A_UNMAPPED, 8'hAA, 8'h00);
        send_item(FUNC_NONE, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(FUNC_TICK, 16'h0000, 8'h00, 8'h00);
        send_item(FUNC_TICK, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(FUNC_WRITE, A_NR30, 8'h00, 8'h00);            // wave dac off
        send_item(FUNC_READ, ADDR_POWER, 8'h00, 8'h00);
        wait_drained();
    endtask

    task automatic random_item();
        logic [15:0] a;
        logic [7:0] v;
        int pick;
        pick = $urandom_range(0, 99);
        a = ADDR_CHAN_FIRST + 16'($urandom_range(0, 47));
        v = 8'($urandom_range(0, 255));
        if (a == ADDR_POWER && $urandom_range(0, 7) != 0) v[7] = 1'b1;
        if (pick < 50)
            send_item(FUNC_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(128, 255)));
        else if (pick < 78) send_item(FUNC_WRITE, a, v, 8'($urandom_range(0, 255)));
        else if (pick < 93) send_item(FUNC_READ, a, 8'h00, 8'($urandom_range(0, 255)));
        else if (pick < 97)
            send_item(2'($urandom_range(1, 2)), 16'($urandom_range(0, 65535)), v, 8'h00);
        else
            send_item(FUNC_NONE, 16'($urandom_range(0, 65535)), v,
                      8'($urandom_range(0, 255)));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) random_item();
    endtask

    task automatic test_backpressure();
        send_item(FUNC_WRITE, ADDR_POWER, 8'h87, 8'h00);
        hold_left = 300;
        for (int i = 0; i < 12; i++) send_item(FUNC_TICK, 16'h0000, 8'h00, 8'hFF);
        wait_drained();
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_item(FUNC_READ, ADDR_POWER, 8'h00, 8'h00);
        test_random(10);
        wait_drained();
    endtask

    initial begin
        int spin;
        in_if.valid = 1'b0;
        in_if.func = FUNC_TICK;
        in_if.address = '0;
        in_if.write_data = '0;
        in_if.cycles = '0;
        sound_reset_state();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        send_item(FUNC_WRITE, ADDR_POWER, 8'h80, 8'h00);
        test_directed();
        send_item(FUNC_WRITE, ADDR_POWER, 8'h80, 8'h00);
        test_random(70);
        test_backpressure();
        test_drain_pause();
        send_item(FUNC_WRITE, ADDR_POWER, 8'h87, 8'h00);
        idling_on = 1'b0;
        test_random(50);
        in_if.valid = 1'b0;
        spin = 0;
        while (pending_results.size() != 0 && spin < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (20) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        $display("sent %0d items; checked %0d samples and %0d register reads",
                 items_sent, samples_seen, reads_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
